FILE: rtl/assert_macros.svh
// Assertion macros shared by the block copy and fill engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define BBMCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bbmcf assertion failed");
// Condition that must never be true at a clock edge.
`define BBMCF_ASSERT_NEVER(lbl, cond) \
  `BBMCF_ASSERT(lbl, !(cond))
`else
`define BBMCF_ASSERT(lbl, prop)
`define BBMCF_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/bbmcf_pkg.sv
// Shared types and constants of the block copy and fill engine.
package bbmcf_pkg;

  // Default memory size in bytes.
  localparam int unsigned MEM_BYTES_DEF = 32768;
  // Widths sized for the largest memory supported (65536 bytes).
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 17;
  localparam int unsigned DATA_W = 8;
  // Command queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_COPY  = 2'd2,
    OP_FILL  = 2'd3
  } op_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    op_e               op;
    logic              reject;
    logic              bwd;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/bbmcf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bbmcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bbmcf_front.sv
// Front end: accepts commands, checks their ranges and classifies them.
module bbmcf_front #(
  parameter int unsigned MEM_BYTES = bbmcf_pkg::MEM_BYTES_DEF
) (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic signed [16:0]  dst_addr_i,
  input  logic signed [16:0]  src_addr_i,
  input  logic [16:0]         length_i,
  input  logic [7:0]          value_i,
  input  logic                clearing_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output bbmcf_pkg::cmd_t     cmd_o
);
  import bbmcf_pkg::*;

  localparam logic [17:0] MemSz = 18'(MEM_BYTES);

  op_e         op;
  logic        dst_in;
  logic        src_in;
  logic        len_nz;
  logic [17:0] dst_end;
  logic [17:0] src_end;
  logic        dst_blk_ok;
  logic        src_blk_ok;
  logic        ok;

  assign op = op_e'(op_i);

  // Start addresses must be non-negative and below the memory size.
  assign dst_in = !dst_addr_i[16] && (18'(dst_addr_i[15:0]) < MemSz);
  assign src_in = !src_addr_i[16] && (18'(src_addr_i[15:0]) < MemSz);

  // Block ranges must be non-empty and end at or before the memory end.
  assign len_nz     = (length_i != '0);
  assign dst_end    = 18'(dst_addr_i[15:0]) + 18'(length_i);
  assign src_end    = 18'(src_addr_i[15:0]) + 18'(length_i);
  assign dst_blk_ok = dst_in && len_nz && (dst_end <= MemSz);
  assign src_blk_ok = src_in && len_nz && (src_end <= MemSz);

  // Acceptance check per command kind.
  always_comb begin
    unique case (op)
      OP_READ:  ok = dst_in;
      OP_WRITE: ok = dst_in;
      OP_COPY:  ok = dst_blk_ok && src_blk_ok;
      OP_FILL:  ok = dst_blk_ok;
      default:  ok = 1'b0;
    endcase
  end

  // Build the queue entry; a copy walks downward when the target lies above the source.
  always_comb begin
    cmd_o.op     = op;
    cmd_o.reject = !ok;
    cmd_o.bwd    = (op == OP_COPY) && (src_addr_i[15:0] < dst_addr_i[15:0]);
    cmd_o.dst    = dst_addr_i[ADDR_W-1:0];
    cmd_o.src    = src_addr_i[ADDR_W-1:0];
    cmd_o.len    = length_i;
    cmd_o.value  = value_i;
  end

  // Hold off input while the memory is cleared or the queue is full.
  assign in_stall_o = clearing_i || queue_full_i;
  assign push_o     = in_valid_i && !in_stall_o;

endmodule

FILE: rtl/bbmcf_queue.sv
// Two-entry command queue between the front and back ends.
`include "assert_macros.svh"
module bbmcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bbmcf_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bbmcf_pkg::cmd_t head_o
);
  import bbmcf_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  `BBMCF_ASSERT_NEVER(a_push_full, push_i && full_o)
  `BBMCF_ASSERT_NEVER(a_pop_empty, pop_i && !valid_o)
  `BBMCF_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH))

endmodule

FILE: rtl/bbmcf_back.sv
// Back end: clears the memory after reset and carries out queued commands.
`include "assert_macros.svh"
module bbmcf_back #(
  parameter int unsigned MEM_BYTES = bbmcf_pkg::MEM_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  bbmcf_pkg::cmd_t head_i,
  output logic            pop_o,
  output logic            clearing_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            status_o
);
  import bbmcf_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned LW = AW + 1;
  localparam logic [AW-1:0] MemLast = AW'(MEM_BYTES - 1);

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_addr_q;
  logic [AW-1:0]     rd_addr_q;
  logic [AW-1:0]     wr_addr_q;
  logic [LW-1:0]     rem_q;
  logic              rd_vld_q;
  logic              bwd_q;
  logic [DATA_W-1:0] fill_val_q;
  logic              rsp_status_q;
  logic [DATA_W-1:0] rsp_data_q;
  logic              out_valid_q;
  logic              out_status_q;
  logic [DATA_W-1:0] out_data_q;

  logic [AW-1:0]     h_dst;
  logic [AW-1:0]     h_src;
  logic [LW-1:0]     h_len;
  logic [AW-1:0]     h_off;
  logic              start;
  logic              out_free;
  logic              out_load;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Queue head fields at the memory's address width.
  assign h_dst = head_i.dst[AW-1:0];
  assign h_src = head_i.src[AW-1:0];
  assign h_len = head_i.len[LW-1:0];
  assign h_off = AW'(h_len - 1'b1);

  assign start    = (state_q == ST_IDLE) && head_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_RESP) && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == MemLast) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          if (head_i.reject) begin
            state_d = ST_RESP;
          end else begin
            unique case (head_i.op)
              OP_READ:  state_d = ST_READ;
              OP_WRITE: state_d = ST_RESP;
              OP_COPY:  state_d = ST_COPY;
              OP_FILL:  state_d = ST_FILL;
              default:  state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_COPY: begin
        if (rem_q == '0 && !rd_vld_q) state_d = ST_RESP;
      end
      ST_FILL: begin
        if (rem_q == LW'(1)) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Memory port control per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = fill_val_q;
    ram_re    = 1'b0;
    ram_raddr = rd_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        if (head_valid_i && !head_i.reject) begin
          if (head_i.op == OP_READ) begin
            ram_re    = 1'b1;
            ram_raddr = h_dst;
          end else if (head_i.op == OP_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = h_dst;
            ram_wdata = head_i.value;
          end
        end
      end
      ST_COPY: begin
        ram_re    = (rem_q != '0);
        ram_we    = rd_vld_q;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign pop_o      = start;
  assign clearing_o = (state_q == ST_CLEAR);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      rd_vld_q    <= (state_q == ST_COPY) && (rem_q != '0);
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Datapath registers: walking addresses, byte count and response.
  always_ff @(posedge clk_i) begin
    if (start) begin
      rsp_status_q <= head_i.reject;
      rsp_data_q   <= '0;
      bwd_q        <= head_i.bwd;
      rem_q        <= h_len;
      fill_val_q   <= head_i.value;
      if (head_i.bwd) begin
        rd_addr_q <= h_src + h_off;
        wr_addr_q <= h_dst + h_off;
      end else begin
        rd_addr_q <= h_src;
        wr_addr_q <= h_dst;
      end
    end
    if (state_q == ST_READ) begin
      rsp_data_q <= ram_rdata;
    end
    if (state_q == ST_COPY) begin
      if (rem_q != '0) begin
        rd_addr_q <= bwd_q ? rd_addr_q - 1'b1 : rd_addr_q + 1'b1;
        rem_q     <= rem_q - 1'b1;
      end
      if (rd_vld_q) begin
        wr_addr_q <= bwd_q ? wr_addr_q - 1'b1 : wr_addr_q + 1'b1;
      end
    end
    if (state_q == ST_FILL) begin
      wr_addr_q <= wr_addr_q + 1'b1;
      rem_q     <= rem_q - 1'b1;
    end
    if (out_load) begin
      out_status_q <= rsp_status_q;
      out_data_q   <= rsp_data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;

  bbmcf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `BBMCF_ASSERT_NEVER(a_rw_same_addr, ram_we && ram_re && (ram_waddr == ram_raddr))
  `BBMCF_ASSERT(a_fill_count, (state_q == ST_FILL) |-> (rem_q != '0))
  `BBMCF_ASSERT(a_waddr_range, ram_we |-> (LW'(ram_waddr) < LW'(MEM_BYTES)))

endmodule

FILE: rtl/bounded_byte_memory_copy_fill.sv
// Top level of the bounded byte memory with read, write, block copy and block fill.
//
// A byte memory of MEM_BYTES bytes that takes one command per transaction and returns one
// result per command: read a byte, write a byte, copy a block (overlap-safe, the walk
// direction is chosen from the two start addresses) or fill a block. Commands with a
// negative or out-of-range address, a zero length or a block that runs past the end are
// rejected with status 1 and leave the memory untouched. After reset the memory is cleared
// one byte per cycle; no command is taken during that time.
// The front end checks ranges and queues up to two commands, so it keeps taking commands
// while the back end works. Fill and copy move one byte per cycle, set by the single RAM
// write port; a copy writes each byte from the registered RAM read port. A finished result
// sits in an output register, so the back end keeps working while the result waits to be
// taken.
module bounded_byte_memory_copy_fill #(
  parameter int unsigned MEM_BYTES = bbmcf_pkg::MEM_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [16:0] dst_addr_i,
  input  logic signed [16:0] src_addr_i,
  input  logic [16:0]        length_i,
  input  logic [7:0]         value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_data_o,
  output logic               status_o
);
  import bbmcf_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;
  logic clearing;

  // Command check and classification.
  bbmcf_front #(
    .MEM_BYTES (MEM_BYTES)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .dst_addr_i   (dst_addr_i),
    .src_addr_i   (src_addr_i),
    .length_i     (length_i),
    .value_i      (value_i),
    .clearing_i   (clearing),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decoupling queue.
  bbmcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_cmd)
  );

  // Command execution against the memory.
  bbmcf_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .status_o     (status_o)
  );

endmodule
